FILE: design/gtpie_pkg.sv
// shared types, codes and decode functions for the gtpv1 ie field extractor
`default_nettype none
package gtpie_pkg;

    localparam int APN_CHARS_DEF    = 128;
    localparam int MSISDN_CHARS_DEF = 32;
    localparam int IMSI_CHARS_DEF   = 17;
    localparam int IMEI_CHARS_DEF   = 17;
    localparam int MAX_REC          = 8;

    localparam logic [5:0] F_CAUSE    = 6'd0;
    localparam logic [5:0] F_IMSI     = 6'd1;
    localparam logic [5:0] F_MCC      = 6'd2;
    localparam logic [5:0] F_MNC      = 6'd3;
    localparam logic [5:0] F_LAC      = 6'd4;
    localparam logic [5:0] F_RAC      = 6'd5;
    localparam logic [5:0] F_TEID_D   = 6'd6;
    localparam logic [5:0] F_TEID_C   = 6'd7;
    localparam logic [5:0] F_TEARDOWN = 6'd8;
    localparam logic [5:0] F_NSAPI    = 6'd9;
    localparam logic [5:0] F_LNSAPI   = 6'd10;
    localparam logic [5:0] F_UEADDR   = 6'd11;
    localparam logic [5:0] F_APN      = 6'd12;
    localparam logic [5:0] F_ADDR1    = 6'd13;
    localparam logic [5:0] F_ADDR2    = 6'd14;
    localparam logic [5:0] F_MSISDN   = 6'd15;
    localparam logic [5:0] F_ARP      = 6'd16;
    localparam logic [5:0] F_DELAY    = 6'd17;
    localparam logic [5:0] F_RELIAB   = 6'd18;
    localparam logic [5:0] F_PREC     = 6'd19;
    localparam logic [5:0] F_TCLASS   = 6'd20;
    localparam logic [5:0] F_SDU      = 6'd21;
    localparam logic [5:0] F_MAXUL    = 6'd22;
    localparam logic [5:0] F_MAXDL    = 6'd23;
    localparam logic [5:0] F_THP      = 6'd24;
    localparam logic [5:0] F_GBRUL    = 6'd25;
    localparam logic [5:0] F_GBRDL    = 6'd26;
    localparam logic [5:0] F_RAT      = 6'd27;
    localparam logic [5:0] F_CID      = 6'd28;
    localparam logic [5:0] F_SAC      = 6'd29;
    localparam logic [5:0] F_IMEI     = 6'd30;
    localparam logic [5:0] F_DTFLAG   = 6'd31;
    localparam logic [5:0] F_END      = 6'd32;

    localparam logic [7:0] IE_CAUSE    = 8'd1;
    localparam logic [7:0] IE_IMSI     = 8'd2;
    localparam logic [7:0] IE_RAI      = 8'd3;
    localparam logic [7:0] IE_TEID_D   = 8'd16;
    localparam logic [7:0] IE_TEID_C   = 8'd17;
    localparam logic [7:0] IE_TEARDOWN = 8'd19;
    localparam logic [7:0] IE_NSAPI    = 8'd20;
    localparam logic [7:0] IE_UEADDR   = 8'd128;
    localparam logic [7:0] IE_APN      = 8'd131;
    localparam logic [7:0] IE_GSNADDR  = 8'd133;
    localparam logic [7:0] IE_MSISDN   = 8'd134;
    localparam logic [7:0] IE_QOS      = 8'd135;
    localparam logic [7:0] IE_RAT      = 8'd151;
    localparam logic [7:0] IE_ULI      = 8'd152;
    localparam logic [7:0] IE_IMEI     = 8'd154;
    localparam logic [7:0] IE_DTFLAG   = 8'd182;

    localparam logic [31:0] RATE_EXT_MARK = 32'd8640000;
    localparam logic [15:0] LAC_RESERVED  = 16'd65534;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_FIXED,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [5:0]  code;
        logic [6:0]  index;
        logic [31:0] value;
        logic        unknown;
    } rec_t;

    typedef struct packed {
        logic [MAX_REC-1:0]     valid;
        rec_t [MAX_REC-1:0]     recs;
    } rec_set_t;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        logic [7:0] r;
        case (d)
            4'd10:   r = 8'h2a;
            4'd11:   r = 8'h23;
            4'd12:   r = 8'h61;
            4'd13:   r = 8'h62;
            4'd14:   r = 8'h63;
            4'd15:   r = 8'h00;
            default: r = 8'h30 + {4'd0, d};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] digit_pair(input logic [7:0] b);
        return {16'd0, digit_ascii(b[3:0]), digit_ascii(b[7:4])};
    endfunction

    function automatic logic [7:0] fixed_len(input logic [7:0] t);
        logic [7:0] r;
        case (t)
            8'd1, 8'd8, 8'd14, 8'd15, 8'd19, 8'd20: r = 8'd1;
            8'd2:                                   r = 8'd8;
            8'd3:                                   r = 8'd6;
            8'd16, 8'd17, 8'd127:                   r = 8'd4;
            8'd26:                                  r = 8'd2;
            default:                                r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic has_length(input logic [7:0] t);
        logic r;
        case (t)
            8'd128, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd137, 8'd148,
            8'd151, 8'd152, 8'd153, 8'd154, 8'd182, 8'd191, 8'd251,
            8'd255: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] base_rate(input logic [7:0] c);
        logic [31:0] k;
        if (c == 8'd0 || c == 8'hff)
            k = 32'd0;
        else if (c <= 8'h3f)
            k = {24'd0, c};
        else if (c <= 8'h7f)
            k = 32'd64 + ({24'd0, c - 8'h40} << 3);
        else
            k = 32'd576 + ({24'd0, c - 8'h80} << 6);
        return k * 32'd1000;
    endfunction

    function automatic logic [31:0] ext_rate(input logic [7:0] c);
        logic [31:0] r;
        if (c == 8'd0 || c == 8'hff)
            r = 32'd0;
        else if (c <= 8'h4a)
            r = 32'd8600000 + {24'd0, c} * 32'd100000;
        else if (c <= 8'hba)
            r = 32'd16000000 + {24'd0, c - 8'h4a} * 32'd1000000;
        else
            r = 32'd128000000 + {24'd0, c - 8'hba} * 32'd2000000;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/gtpie_parser.sv
// per-octet ie parser: framing state and record generation for one item
`default_nettype none
module gtpie_parser
    import gtpie_pkg::*;
#(
    parameter int APN_CHARS    = APN_CHARS_DEF,
    parameter int MSISDN_CHARS = MSISDN_CHARS_DEF,
    parameter int IMSI_CHARS   = IMSI_CHARS_DEF,
    parameter int IMEI_CHARS   = IMEI_CHARS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire logic [7:0] data_byte,
    input  wire logic     message_last,
    output rec_set_t      rec_set
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  ie_type_reg, ie_type_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  apn_count_reg, apn_count_next;
    logic [7:0]  apn_rem_reg, apn_rem_next;
    logic        apn_stop_reg, apn_stop_next;
    logic        nsapi_seen_reg, nsapi_seen_next;
    logic        addr_seen_reg, addr_seen_next;
    logic        skip_reg, skip_next;
    logic [7:0]  loc_kind_reg, loc_kind_next;
    logic [7:0]  qos_reg [8];
    logic [7:0]  qos_next [8];

    rec_set_t    rs;
    logic [2:0]  n;

    always_comb
    begin
        logic [7:0]  fl;
        logic [7:0]  b;
        logic [15:0] k;
        logic [15:0] l;
        logic [31:0] a;
        logic [31:0] v;
        logic [16:0] kp1;
        logic [16:0] r;
        logic        in_body_after;
        integer      left;
        b = data_byte;
        phase_next      = phase_reg;
        ie_type_next    = ie_type_reg;
        offset_next     = offset_reg;
        length_next     = length_reg;
        acc_next        = acc_reg;
        apn_count_next  = apn_count_reg;
        apn_rem_next    = apn_rem_reg;
        apn_stop_next   = apn_stop_reg;
        nsapi_seen_next = nsapi_seen_reg;
        addr_seen_next  = addr_seen_reg;
        skip_next       = skip_reg;
        loc_kind_next   = loc_kind_reg;
        for (int i = 0; i < 8; i++)
            qos_next[i] = qos_reg[i];
        rs = '0;
        n  = 3'd0;
        k  = offset_reg;
        l  = length_reg;
        kp1 = {1'b0, k} + 17'd1;
        a  = {acc_reg[23:0], b};
        fl = fixed_len(b);
        r  = 17'd0;
        v  = 32'd0;
        left = 0;
        in_body_after = 1'b0;

        if (!skip_reg)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    ie_type_next   = b;
                    offset_next    = 16'd0;
                    acc_next       = 32'd0;
                    apn_count_next = 8'd0;
                    apn_rem_next   = 8'd0;
                    apn_stop_next  = 1'b0;
                    loc_kind_next  = 8'd0;
                    if (fl != 8'd0)
                    begin
                        length_next = {8'd0, fl};
                        phase_next  = PH_FIXED;
                    end
                    else if (has_length(b))
                        phase_next = PH_LEN_HI;
                    else
                        skip_next = 1'b1;
                end
                PH_FIXED:
                begin
                    acc_next    = a;
                    offset_next = kp1[15:0];
                    if (kp1 >= {1'b0, l})
                        phase_next = PH_TYPE;
                    case (ie_type_reg)
                        IE_CAUSE:
                        begin
                            rs.recs[n] = '{F_CAUSE, 7'd0, {24'd0, b}, 1'b0};
                            rs.valid[n] = 1'b1; n = n + 3'd1;
                        end
                        IE_IMSI:
                            if (2 * int'(k) + 2 <= IMSI_CHARS - 1)
                            begin
                                rs.recs[n] = '{F_IMSI, k[6:0], digit_pair(b), 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                        IE_RAI:
                            if (k == 16'd1)
                            begin
                                rs.recs[n] = '{F_MCC, 7'd0, {16'd0, a[15:0]}, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                            else if (k == 16'd2)
                            begin
                                rs.recs[n] = '{F_MNC, 7'd0, {16'd0, a[15:0]}, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                            else if (k == 16'd4 && a[15:0] != LAC_RESERVED
                                     && a[15:0] != 16'd0)
                            begin
                                rs.recs[n] = '{F_LAC, 7'd0, {16'd0, a[15:0]}, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                            else if (k == 16'd5 && b != 8'hff)
                            begin
                                rs.recs[n] = '{F_RAC, 7'd0, {24'd0, b}, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                        IE_TEID_D, IE_TEID_C:
                            if (k == 16'd3)
                            begin
                                rs.recs[n] = '{(ie_type_reg == IE_TEID_D) ? F_TEID_D
                                               : F_TEID_C, 7'd0, a, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                        IE_TEARDOWN:
                        begin
                            rs.recs[n] = '{F_TEARDOWN, 7'd0, {31'd0, b[0]}, 1'b0};
                            rs.valid[n] = 1'b1; n = n + 3'd1;
                        end
                        IE_NSAPI:
                        begin
                            rs.recs[n] = '{nsapi_seen_reg ? F_LNSAPI : F_NSAPI, 7'd0,
                                           {24'd0, b}, 1'b0};
                            rs.valid[n] = 1'b1; n = n + 3'd1;
                            nsapi_seen_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                PH_LEN_HI:
                begin
                    length_next = {b, 8'd0};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {length_reg[15:8], b};
                    offset_next = 16'd0;
                    phase_next  = ({length_reg[15:8], b} == 16'd0) ? PH_TYPE : PH_BODY;
                end
                default:
                begin
                    acc_next    = a;
                    offset_next = kp1[15:0];
                    case (ie_type_reg)
                        IE_UEADDR:
                            if (l == 16'd6 && k == 16'd5)
                            begin
                                rs.recs[n] = '{F_UEADDR, 7'd0, a, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                        IE_APN:
                            if (!apn_stop_reg)
                            begin
                                if (apn_rem_reg == 8'd0)
                                begin
                                    left = APN_CHARS - int'(apn_count_reg);
                                    if (int'(b) > left)
                                        apn_stop_next = 1'b1;
                                    else
                                    begin
                                        apn_rem_next = b;
                                        if (b == 8'd0 && kp1 < {1'b0, l})
                                        begin
                                            if (int'(apn_count_reg) < APN_CHARS - 1)
                                            begin
                                                rs.recs[n] = '{F_APN, apn_count_reg[6:0],
                                                               32'h2e, 1'b0};
                                                rs.valid[n] = 1'b1; n = n + 3'd1;
                                            end
                                            if (apn_count_reg != 8'hff)
                                                apn_count_next = apn_count_reg + 8'd1;
                                        end
                                    end
                                end
                                else
                                begin
                                    if (int'(apn_count_reg) < APN_CHARS - 1)
                                    begin
                                        rs.recs[n] = '{F_APN, apn_count_reg[6:0],
                                                       {24'd0, b}, 1'b0};
                                        rs.valid[n] = 1'b1; n = n + 3'd1;
                                    end
                                    apn_count_next = apn_count_reg;
                                    if (apn_count_reg != 8'hff)
                                        apn_count_next = apn_count_reg + 8'd1;
                                    apn_rem_next = apn_rem_reg - 8'd1;
                                    if (apn_rem_reg == 8'd1 && kp1 < {1'b0, l})
                                    begin
                                        if (int'(apn_count_next) < APN_CHARS - 1)
                                        begin
                                            rs.recs[n] = '{F_APN, apn_count_next[6:0],
                                                           32'h2e, 1'b0};
                                            rs.valid[n] = 1'b1; n = n + 3'd1;
                                        end
                                        if (apn_count_next != 8'hff)
                                            apn_count_next = apn_count_next + 8'd1;
                                    end
                                end
                            end
                        IE_GSNADDR:
                            if (l == 16'd4 && k == 16'd3)
                            begin
                                rs.recs[n] = '{addr_seen_reg ? F_ADDR2 : F_ADDR1, 7'd0,
                                               a, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                                addr_seen_next = 1'b1;
                            end
                        IE_MSISDN:
                            if (k >= 16'd1 && 2 * (int'(k) - 1) + 2 <= MSISDN_CHARS - 1)
                            begin
                                rs.recs[n] = '{F_MSISDN, 7'(k - 16'd1), digit_pair(b), 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                        IE_QOS:
                            case (k)
                                16'd0:
                                begin
                                    rs.recs[n] = '{F_ARP, 7'd0, {24'd0, b}, 1'b0};
                                    rs.valid[n] = 1'b1; n = n + 3'd1;
                                end
                                16'd1:
                                begin
                                    rs.recs[n] = '{F_DELAY, 7'd0, {27'd0, b[7:3]}, 1'b0};
                                    rs.valid[n] = 1'b1; n = n + 3'd1;
                                    rs.recs[n] = '{F_RELIAB, 7'd0, {29'd0, b[2:0]}, 1'b0};
                                    rs.valid[n] = 1'b1; n = n + 3'd1;
                                end
                                16'd2:
                                begin
                                    rs.recs[n] = '{F_PREC, 7'd0, {29'd0, b[2:0]}, 1'b0};
                                    rs.valid[n] = 1'b1; n = n + 3'd1;
                                end
                                16'd4:
                                begin
                                    rs.recs[n] = '{F_TCLASS, 7'd0, {29'd0, b[7:5]}, 1'b0};
                                    rs.valid[n] = 1'b1; n = n + 3'd1;
                                end
                                16'd5:
                                begin
                                    rs.recs[n] = '{F_SDU, 7'd0, {24'd0, b} * 32'd10, 1'b0};
                                    rs.valid[n] = 1'b1; n = n + 3'd1;
                                end
                                16'd6:  qos_next[0] = b;
                                16'd7:  qos_next[1] = b;
                                16'd9:
                                begin
                                    rs.recs[n] = '{F_THP, 7'd0, {29'd0, b[2:0]}, 1'b0};
                                    rs.valid[n] = 1'b1; n = n + 3'd1;
                                end
                                16'd10: qos_next[2] = b;
                                16'd11: qos_next[3] = b;
                                16'd13: qos_next[4] = b;
                                16'd14: qos_next[5] = b;
                                16'd15: qos_next[6] = b;
                                16'd16: qos_next[7] = b;
                                default:
                                begin
                                end
                            endcase
                        IE_RAT:
                            if (k == 16'd0)
                            begin
                                rs.recs[n] = '{F_RAT, 7'd0, {24'd0, b}, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                        IE_ULI:
                            if (k == 16'd0)
                                loc_kind_next = b;
                            else if (k == 16'd2)
                            begin
                                rs.recs[n] = '{F_MCC, 7'd0, {16'd0, a[15:0]}, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                            else if (k == 16'd3)
                            begin
                                rs.recs[n] = '{F_MNC, 7'd0, {16'd0, a[15:0]}, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                            else if (k == 16'd5 && loc_kind_reg <= 8'd2)
                            begin
                                rs.recs[n] = '{F_LAC, 7'd0, {16'd0, a[15:0]}, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                            else if (k == 16'd7 && loc_kind_reg <= 8'd2)
                            begin
                                rs.recs[n] = '{(loc_kind_reg == 8'd0) ? F_CID :
                                               (loc_kind_reg == 8'd1) ? F_SAC : F_RAC,
                                               7'd0, {16'd0, a[15:0]}, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                        IE_IMEI:
                            if (k < 16'd8 && 2 * int'(k) + 2 <= IMEI_CHARS - 1)
                            begin
                                rs.recs[n] = '{F_IMEI, k[6:0], digit_pair(b), 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                        IE_DTFLAG:
                            if (k == 16'd0 && b[0])
                            begin
                                rs.recs[n] = '{F_DTFLAG, 7'd0, 32'd1, 1'b0};
                                rs.valid[n] = 1'b1; n = n + 3'd1;
                            end
                        default:
                        begin
                        end
                    endcase
                    if (kp1 >= {1'b0, l})
                    begin
                        phase_next = PH_TYPE;
                        if (ie_type_reg == IE_QOS)
                            r = {1'b0, l};
                    end
                    else if (message_last && ie_type_reg == IE_QOS)
                    begin
                        in_body_after = 1'b1;
                        r = kp1;
                    end
                end
            endcase
        end

        // qos bitrate flush at ie end or message end
        if (r > 17'd6)
        begin
            v = base_rate(qos_next[0]);
            if (v == RATE_EXT_MARK && l >= 16'd17 && r > 17'd15)
                v = ext_rate(qos_next[6]);
            rs.recs[n] = '{F_MAXUL, 7'd0, v, 1'b0};
            rs.valid[n] = 1'b1; n = n + 3'd1;
        end
        if (r > 17'd7)
        begin
            v = base_rate(qos_next[1]);
            if (v == RATE_EXT_MARK && l >= 16'd15 && r > 17'd13)
                v = ext_rate(qos_next[4]);
            rs.recs[n] = '{F_MAXDL, 7'd0, v, 1'b0};
            rs.valid[n] = 1'b1; n = n + 3'd1;
        end
        if (r > 17'd10)
        begin
            v = base_rate(qos_next[2]);
            if (v == RATE_EXT_MARK && l >= 16'd18 && r > 17'd16)
                v = ext_rate(qos_next[7]);
            rs.recs[n] = '{F_GBRUL, 7'd0, v, 1'b0};
            rs.valid[n] = 1'b1; n = n + 3'd1;
        end
        if (r > 17'd11)
        begin
            v = base_rate(qos_next[3]);
            if (v == RATE_EXT_MARK && l >= 16'd16 && r > 17'd14)
                v = ext_rate(qos_next[5]);
            rs.recs[n] = '{F_GBRDL, 7'd0, v, 1'b0};
            rs.valid[n] = 1'b1; n = n + 3'd1;
        end

        // at most four records precede the end record
        if (message_last)
        begin
            rs.recs[n] = '{F_END, 7'd0, 32'd0, skip_next};
            rs.valid[n] = 1'b1;
            phase_next      = PH_TYPE;
            ie_type_next    = 8'd0;
            offset_next     = 16'd0;
            length_next     = 16'd0;
            acc_next        = 32'd0;
            apn_count_next  = 8'd0;
            apn_rem_next    = 8'd0;
            apn_stop_next   = 1'b0;
            nsapi_seen_next = 1'b0;
            addr_seen_next  = 1'b0;
            skip_next       = 1'b0;
            loc_kind_next   = 8'd0;
        end
        if (in_body_after)
            r = 17'd0;
    end

    assign rec_set = rs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TYPE;
            ie_type_reg    <= 8'd0;
            offset_reg     <= 16'd0;
            length_reg     <= 16'd0;
            acc_reg        <= 32'd0;
            apn_count_reg  <= 8'd0;
            apn_rem_reg    <= 8'd0;
            apn_stop_reg   <= 1'b0;
            nsapi_seen_reg <= 1'b0;
            addr_seen_reg  <= 1'b0;
            skip_reg       <= 1'b0;
            loc_kind_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            ie_type_reg    <= ie_type_next;
            offset_reg     <= offset_next;
            length_reg     <= length_next;
            acc_reg        <= acc_next;
            apn_count_reg  <= apn_count_next;
            apn_rem_reg    <= apn_rem_next;
            apn_stop_reg   <= apn_stop_next;
            nsapi_seen_reg <= nsapi_seen_next;
            addr_seen_reg  <= addr_seen_next;
            skip_reg       <= skip_next;
            loc_kind_reg   <= loc_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            for (int i = 0; i < 8; i++)
                qos_reg[i] <= qos_next[i];
    end

endmodule
`default_nettype wire

FILE: design/gtpie_out_queue.sv
// result queue: holds the record set of one octet and drains it one item per cycle while ready is high
`default_nettype none
module gtpie_out_queue
    import gtpie_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire rec_set_t    rec_set,
    output logic             can_load,
    output logic             valid,
    input  wire logic        ready,
    output logic [5:0]       field_code,
    output logic [6:0]       element_index,
    output logic [31:0]      field_value,
    output logic             unknown_ie_seen,
    output logic             run_last
);

    logic [MAX_REC-1:0] pend_reg, pend_next;
    rec_t [MAX_REC-1:0] recs_reg;
    logic [2:0]         head;
    logic [MAX_REC-1:0] rest;
    logic               fire;

    always_comb
    begin
        head = 3'd0;
        for (int i = MAX_REC - 1; i >= 0; i--)
            if (pend_reg[i])
                head = 3'(i);
        rest = pend_reg;
        rest[head] = 1'b0;
    end

    assign valid    = |pend_reg;
    assign fire     = valid && ready;
    assign can_load = !valid || (fire && rest == '0);

    assign field_code      = recs_reg[head].code;
    assign element_index   = recs_reg[head].index;
    assign field_value     = recs_reg[head].value;
    assign unknown_ie_seen = recs_reg[head].unknown;
    assign run_last        = (rest == '0);

    always_comb
    begin
        pend_next = pend_reg;
        if (fire)
            pend_next = rest;
        if (load)
            pend_next = rec_set.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            recs_reg <= rec_set.recs;
    end

endmodule
`default_nettype wire

FILE: design/gtpv1_ie_field_extractor_unit.sv
// top level of the gtpv1 ie field extractor
// One octet is accepted per cycle with out_ready high and at most one record from
// the octet before; an octet causing more holds the input until its last record
// is taken, as the result queue delivers one record per cycle with out_ready high.
// Records are shown from the cycle after their octet is accepted, the last marked
// by run_last; a message's final octet adds an end record carrying unknown_ie_seen.
`default_nettype none
module gtpv1_ie_field_extractor_unit
    import gtpie_pkg::*;
#(
    parameter int APN_CHARS    = APN_CHARS_DEF,
    parameter int MSISDN_CHARS = MSISDN_CHARS_DEF,
    parameter int IMSI_CHARS   = IMSI_CHARS_DEF,
    parameter int IMEI_CHARS   = IMEI_CHARS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        message_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       field_code,
    output logic [6:0]       element_index,
    output logic [31:0]      field_value,
    output logic             unknown_ie_seen,
    output logic             run_last
);

    rec_set_t rec_set;
    logic     step;

    assign step = in_valid && in_ready;

    gtpie_parser #(
        .APN_CHARS    (APN_CHARS),
        .MSISDN_CHARS (MSISDN_CHARS),
        .IMSI_CHARS   (IMSI_CHARS),
        .IMEI_CHARS   (IMEI_CHARS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (data_byte),
        .message_last (message_last),
        .rec_set      (rec_set)
    );

    gtpie_out_queue u_queue (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (step),
        .rec_set         (rec_set),
        .can_load        (in_ready),
        .valid           (out_valid),
        .ready           (out_ready),
        .field_code      (field_code),
        .element_index   (element_index),
        .field_value     (field_value),
        .unknown_ie_seen (unknown_ie_seen),
        .run_last        (run_last)
    );

endmodule
`default_nettype wire
